// ===== hw/rtl/convex_polygon_line_clipper_core_defines.svh =====
// Assertion macros used by the port-level checker.
`ifndef CONVEX_POLYGON_LINE_CLIPPER_CORE_DEFINES_SVH
`define CONVEX_POLYGON_LINE_CLIPPER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CPLC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CPLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/cplc_pkg.sv =====
// Package with shared types, constants and the sequencer states of the clipper.
package cplc_pkg;
    localparam int MAX_EDGES_DEF  = 6;
    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 8;
    localparam int T_BITS         = 16;
    localparam logic [16:0] T_ONE = 17'd32768;

    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_COUNT = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_FIRST = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_LAST  = 8'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_BBOX       = 8'd7;

    localparam logic [3:0] CODE_UP    = 4'h8;
    localparam logic [3:0] CODE_DOWN  = 4'h4;
    localparam logic [3:0] CODE_LEFT  = 4'h2;
    localparam logic [3:0] CODE_RIGHT = 4'h1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CODE,
        ST_DOT,
        ST_EDGE,
        ST_DIV,
        ST_ACC,
        ST_INTERP,
        ST_OUT
    } cplc_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic code;
        logic dot;
        logic edge_eval;
        logic div_step;
        logic acc;
        logic interp;
    } cplc_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic reject;
        logic need_div;
        logic div_last;
        logic last_edge;
        logic no_edges;
        logic interp_last;
    } cplc_sts_t;
endpackage

// ===== hw/rtl/cplc_ctrl.sv =====
// Sequencer of the clipper: walks outcodes, edges, division and interpolation.
module cplc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_xfer,
    input  logic                out_xfer,
    input  cplc_pkg::cplc_sts_t sts,
    output cplc_pkg::cplc_cmd_t cmd,
    output logic                busy,
    output logic                out_valid
);
    import cplc_pkg::*;

    cplc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                if (in_xfer) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CODE;
                end
            end
            ST_CODE: begin
                cmd.code = 1'b1;
                if (sts.reject) state_next = ST_OUT;
                else if (sts.no_edges) state_next = ST_INTERP;
                else state_next = ST_DOT;
            end
            ST_DOT: begin
                cmd.dot    = 1'b1;
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                cmd.edge_eval = 1'b1;
                if (sts.need_div) state_next = ST_DIV;
                else if (sts.last_edge) state_next = ST_INTERP;
                else state_next = ST_DOT;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (sts.last_edge) state_next = ST_INTERP;
                else state_next = ST_DOT;
            end
            ST_INTERP: begin
                cmd.interp = 1'b1;
                if (sts.interp_last) state_next = ST_OUT;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_xfer) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/cplc_datapath.sv =====
// Datapath of the clipper: registers, dot products, divider and interpolator.
module cplc_datapath #(
    parameter int MAX_EDGES  = cplc_pkg::MAX_EDGES_DEF,
    parameter int COORD_BITS = cplc_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [cplc_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
    input  logic [63:0]                        cfg_data,
    input  logic [4*COORD_BITS-1:0]            in_data,
    input  cplc_pkg::cplc_cmd_t                cmd,
    output cplc_pkg::cplc_sts_t                sts,
    output logic                               res_visible,
    output logic [4*COORD_BITS-1:0]            res_pts,
    output logic [15:0]                        res_t_enter,
    output logic [15:0]                        res_t_exit
);
    import cplc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DB = CB + 1;          // coordinate differences
    localparam int PB = DB + 16;         // one product of a difference and a normal
    localparam int SB = PB + 1;          // dot product
    localparam int IB = DB + 17 + 1;     // interpolation product

    logic [2:0]  edge_count_reg;
    logic [63:0] edge_word_reg [MAX_EDGES];
    logic [63:0] bbox_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_count_reg <= 3'd5;
            bbox_reg       <= '0;
            for (int i = 0; i < MAX_EDGES; i++) edge_word_reg[i] <= '0;
        end else if (cfg_we) begin
            if (cfg_idx == REG_EDGE_COUNT) edge_count_reg <= cfg_data[2:0];
            else if (cfg_idx == REG_BBOX) bbox_reg <= cfg_data;
            else if (cfg_idx >= REG_EDGE_FIRST && cfg_idx <= REG_EDGE_LAST) begin
                for (int i = 0; i < MAX_EDGES; i++)
                    if (cfg_idx == CFG_IDX_BITS'(i + 1)) edge_word_reg[i] <= cfg_data;
            end
        end
    end

    logic signed [CB-1:0] px_reg, py_reg, qx_reg, qy_reg;
    logic signed [DB-1:0] dx_reg, dy_reg;
    logic [EI-1:0]        edge_reg;
    logic [2:0]           n_reg;
    logic [16:0]          t0_reg, t1_reg;
    logic                 vis_reg;
    logic signed [PB-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [SB-1:0]        rem_reg, den_reg;
    logic [15:0]          q_reg;
    logic [3:0]           dcnt_reg;
    logic                 dexit_reg;
    logic [2:0]           icnt_reg;
    logic signed [CB-1:0] out_reg [4];

    wire signed [15:0] bminx = bbox_reg[15:0];
    wire signed [15:0] bminy = bbox_reg[31:16];
    wire signed [15:0] bmaxx = bbox_reg[47:32];
    wire signed [15:0] bmaxy = bbox_reg[63:48];

    function automatic logic [3:0] outc(input logic signed [CB-1:0] x,
                                        input logic signed [CB-1:0] y,
                                        input logic signed [15:0] mnx,
                                        input logic signed [15:0] mny,
                                        input logic signed [15:0] mxx,
                                        input logic signed [15:0] mxy);
        logic [3:0] c;
        c = '0;
        if (32'(y) > 32'(mxy)) c = c | CODE_UP;
        else if (32'(y) < 32'(mny)) c = c | CODE_DOWN;
        if (32'(x) < 32'(mnx)) c = c | CODE_LEFT;
        else if (32'(x) > 32'(mxx)) c = c | CODE_RIGHT;
        return c;
    endfunction

    wire [3:0] code_p = outc(px_reg, py_reg, bminx, bminy, bmaxx, bmaxy);
    wire [3:0] code_q = outc(qx_reg, qy_reg, bminx, bminy, bmaxx, bmaxy);

    wire [63:0]         ew = edge_word_reg[edge_reg];
    wire signed [15:0]  eox = ew[15:0];
    wire signed [15:0]  eoy = ew[31:16];
    wire signed [15:0]  enx = ew[47:32];
    wire signed [15:0]  eny = ew[63:48];
    wire signed [DB-1:0] wx = DB'(px_reg) - DB'(eox);
    wire signed [DB-1:0] wy = DB'(py_reg) - DB'(eoy);

    wire signed [SB-1:0] dd = SB'(pa_reg) + SB'(pb_reg);
    wire signed [SB-1:0] dw = SB'(pc_reg) + SB'(pd_reg);
    wire signed [SB-1:0] ndw = -dw;
    wire signed [SB-1:0] ndd = -dd;
    wire last_e = (EI+1)'(edge_reg) + 1'b1 >= (EI+1)'(n_reg);

    // Edge decision
    logic e_rej, e_div, e_exit, e_set0, e_set1;
    logic [16:0] e_t;
    always_comb begin
        e_rej = 1'b0; e_div = 1'b0; e_exit = 1'b0; e_set0 = 1'b0; e_set1 = 1'b0;
        e_t = '0;
        if (dd > 0) begin
            if (ndw > dd) e_rej = 1'b1;
            else if (ndw > 0) begin
                if (ndw == dd) begin e_set0 = 1'b1; e_t = T_ONE; end
                else e_div = 1'b1;
            end
        end else if (dd < 0) begin
            e_exit = 1'b1;
            if (dw < 0) e_rej = 1'b1;
            else if (dw < ndd) begin
                if (dw == 0) begin e_set1 = 1'b1; e_t = '0; end
                else e_div = 1'b1;
            end
        end else if (dw < 0) e_rej = 1'b1;
    end

    wire [SB:0] rsh  = {rem_reg, 1'b0};
    wire        rge  = rsh >= {1'b0, den_reg};
    wire [SB:0] rsub = rsh - {1'b0, den_reg};

    // Interpolation: one coordinate per cycle through a single multiplier.
    wire [1:0] isel = icnt_reg[1:0];
    logic signed [CB-1:0] ip;
    logic signed [DB-1:0] id;
    logic [16:0]          it;
    always_comb begin
        case (isel)
            2'd0: begin ip = px_reg; id = dx_reg; it = t0_reg; end
            2'd1: begin ip = py_reg; id = dy_reg; it = t0_reg; end
            2'd2: begin ip = px_reg; id = dx_reg; it = t1_reg; end
            default: begin ip = py_reg; id = dy_reg; it = t1_reg; end
        endcase
    end
    wire signed [IB-1:0] iprod = IB'($signed({1'b0, it})) * IB'(id) + IB'(16384);
    wire signed [IB-1:0] ifl   = iprod >>> 15;
    wire signed [IB-1:0] isum  = ifl + IB'(ip);
    localparam logic signed [IB-1:0] HI = IB'((64'd1 << (CB - 1)) - 64'd1);
    localparam logic signed [IB-1:0] LO = -HI - IB'(1);
    wire signed [CB-1:0] isat = (isum > HI) ? CB'(HI) : (isum < LO) ? CB'(LO) : CB'(isum);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg   <= in_data[CB-1:0];
            py_reg   <= in_data[2*CB-1:CB];
            qx_reg   <= in_data[3*CB-1:2*CB];
            qy_reg   <= in_data[4*CB-1:3*CB];
            dx_reg   <= DB'($signed(in_data[3*CB-1:2*CB])) - DB'($signed(in_data[CB-1:0]));
            dy_reg   <= DB'($signed(in_data[4*CB-1:3*CB])) - DB'($signed(in_data[2*CB-1:CB]));
            t0_reg   <= '0;
            t1_reg   <= T_ONE;
            vis_reg  <= 1'b1;
            edge_reg <= '0;
            icnt_reg <= '0;
            n_reg    <= (32'(edge_count_reg) > MAX_EDGES) ? 3'(MAX_EDGES) : edge_count_reg;
        end
        if (cmd.code && ((code_p & code_q) != 4'd0)) vis_reg <= 1'b0;
        if (cmd.dot) begin
            pa_reg <= PB'(dx_reg) * PB'(enx);
            pb_reg <= PB'(dy_reg) * PB'(eny);
            pc_reg <= PB'(wx) * PB'(enx);
            pd_reg <= PB'(wy) * PB'(eny);
        end
        if (cmd.edge_eval) begin
            if (e_rej) vis_reg <= 1'b0;
            if (e_set0 && e_t > t0_reg) t0_reg <= e_t;
            if (e_set1 && e_t < t1_reg) t1_reg <= e_t;
            rem_reg   <= e_exit ? dw : ndw;
            den_reg   <= e_exit ? ndd : dd;
            q_reg     <= '0;
            dcnt_reg  <= '0;
            dexit_reg <= e_exit;
            if (!e_div && !last_e) edge_reg <= edge_reg + 1'b1;
        end
        if (cmd.div_step) begin
            rem_reg  <= rge ? rsub[SB-1:0] : rsh[SB-1:0];
            q_reg    <= {q_reg[14:0], rge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.acc) begin
            if (dexit_reg) begin
                if ({1'b0, q_reg} < t1_reg) t1_reg <= {1'b0, q_reg};
            end else if ({1'b0, q_reg} > t0_reg) t0_reg <= {1'b0, q_reg};
            if (!last_e) edge_reg <= edge_reg + 1'b1;
        end
        if (cmd.interp) begin
            out_reg[isel] <= isat;
            icnt_reg      <= icnt_reg + 1'b1;
        end
    end

    always_comb begin
        sts.reject      = (code_p & code_q) != 4'd0;
        sts.no_edges    = n_reg == 3'd0;
        sts.need_div    = e_div;
        sts.div_last    = dcnt_reg == 4'd14;
        sts.last_edge   = last_e;
        sts.interp_last = icnt_reg == 3'd3;
    end

    wire ok = vis_reg && (t0_reg <= t1_reg);
    assign res_visible = ok;
    assign res_pts     = ok ? {out_reg[3], out_reg[2], out_reg[1], out_reg[0]} : '0;
    assign res_t_enter = ok ? t0_reg[15:0] : '0;
    assign res_t_exit  = ok ? t1_reg[15:0] : '0;
endmodule

// ===== hw/rtl/convex_polygon_line_clipper_core.sv =====
// Top level of the convex polygon line clipper.
//  channel | direction | contents
//  s_axis  | in        | segment end points (start_x, start_y, end_x, end_y)
//  m_axis  | out       | visible in tuser; clipped points and t values in tdata
//  cfg     | in        | register index and 64-bit write data
// One segment is worked at a time. A segment goes through accept and outcode test,
// a dot product and edge step per edge, the shared 15-step restoring divider for each
// edge that needs it, interpolation of four coordinates on one shared multiplier, and
// the result.
// A bounding-box rejection goes from the outcode test straight to the result.
// The result is held until the output transfer completes; the next segment is taken
// after that.
// Reset is synchronous and active low and restores edge_count to 5, edge words and box to 0.
module convex_polygon_line_clipper_core #(
    parameter int MAX_EDGES  = cplc_pkg::MAX_EDGES_DEF,
    parameter int COORD_BITS = cplc_pkg::COORD_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [(4*COORD_BITS+7)/8*8-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y, t_enter, t_exit
    output logic [(4*COORD_BITS+32+7)/8*8-1:0] m_axis_tdata,
    // visible
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cplc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [63:0]                       cfg_data
);
    import cplc_pkg::*;

    localparam int OW = (4*COORD_BITS+32+7)/8*8;

    cplc_cmd_t cmd;
    cplc_sts_t sts;
    logic busy;
    logic [4*COORD_BITS-1:0] pts;
    logic [15:0] te, tx;
    logic vis;

    assign s_axis_tready = !busy;
    assign cfg_ready     = 1'b1;

    cplc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_xfer(s_axis_tvalid && s_axis_tready),
        .out_xfer(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
    );

    cplc_datapath #(.MAX_EDGES(MAX_EDGES), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_data(s_axis_tdata[4*COORD_BITS-1:0]),
        .cmd(cmd), .sts(sts),
        .res_visible(vis), .res_pts(pts), .res_t_enter(te), .res_t_exit(tx)
    );

    assign m_axis_tdata = OW'({tx, te, pts});
    assign m_axis_tuser = vis;
endmodule

// ===== hw/rtl/cplc_checker.sv =====
// Port-level checker of the clipper, bound to the top level.
`include "convex_polygon_line_clipper_core_defines.svh"
module cplc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic        m_axis_tuser,
    input logic [95:0] m_axis_tdata
);
    `CPLC_ASSERT_IMP(a_no_in_while_out, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `CPLC_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CPLC_ASSERT_IMP(a_reject_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    `CPLC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind convex_polygon_line_clipper_core cplc_checker u_cplc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the convex polygon line clipper core.
module testbench;
    import cplc_pkg::*;

    localparam int    CB        = COORD_BITS_DEF;
    localparam int    WDOG_MAX  = 6000;
    localparam int    HOLD_LEN  = 400;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = REG_BBOX + 8'd1;

    typedef struct packed {
        logic        visible;
        logic [15:0] sx, sy, ex, ey, t_in, t_out;
    } clip_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    convex_polygon_line_clipper_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the clipper registers.
    logic [2:0]  sh_edge_count = 3'd5;
    logic [63:0] sh_edge [6] = '{default: '0};
    logic [63:0] sh_bbox = '0;

    logic [63:0] seg_queue [$];
    clip_res_t   clip_expected [$];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;
    int          wdog = 0;

    initial forever #5 aclk = ~aclk;

    function automatic longint lane16(logic [63:0] w, int k);
        logic [15:0] v;
        v = w[16*k +: 16];
        return longint'($signed(v));
    endfunction

    function automatic logic [3:0] box_code(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (y > lane16(sh_bbox, 3)) c |= CODE_UP;
        else if (y < lane16(sh_bbox, 1)) c |= CODE_DOWN;
        if (x < lane16(sh_bbox, 0)) c |= CODE_LEFT;
        else if (x > lane16(sh_bbox, 2)) c |= CODE_RIGHT;
        return c;
    endfunction

    // Fifteen-step restoring division, giving floor(num * 2^15 / den).
    function automatic longint frac_quot(longint num, longint den);
        longint r, q;
        r = num;
        q = 0;
        for (int i = 0; i < 15; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic logic [15:0] lerp_point(longint p, longint d, longint t);
        longint v;
        v = p + ((t * d + 16384) >>> 15);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic clip_res_t clip_segment(logic [63:0] seg);
        clip_res_t r;
        longint px, py, qx, qy, dx, dy, ox, oy, nx, ny, dd, dw, num, t, t0, t1;
        int n;
        bit vis;
        r = '0;
        px = lane16(seg, 0);
        py = lane16(seg, 1);
        qx = lane16(seg, 2);
        qy = lane16(seg, 3);
        dx = qx - px;
        dy = qy - py;
        t0 = 0;
        t1 = T_ONE;
        vis = 1'b1;
        n = (sh_edge_count > MAX_EDGES_DEF) ? MAX_EDGES_DEF : sh_edge_count;
        if ((box_code(px, py) & box_code(qx, qy)) != 0) return r;
        for (int i = 0; i < n; i++) begin
            ox = lane16(sh_edge[i], 0);
            oy = lane16(sh_edge[i], 1);
            nx = lane16(sh_edge[i], 2);
            ny = lane16(sh_edge[i], 3);
            dd = dx * nx + dy * ny;
            dw = (px - ox) * nx + (py - oy) * ny;
            if (dd > 0) begin
                num = -dw;
                if (num > dd) vis = 1'b0;
                else if (num > 0) begin
                    t = (num == dd) ? T_ONE : frac_quot(num, dd);
                    if (t > t0) t0 = t;
                end
            end else if (dd < 0) begin
                if (dw < 0) vis = 1'b0;
                else if (dw < -dd) begin
                    t = (dw == 0) ? 0 : frac_quot(dw, -dd);
                    if (t < t1) t1 = t;
                end
            end else if (dw < 0) begin
                vis = 1'b0;
            end
        end
        if (t0 > t1) vis = 1'b0;
        if (!vis) return r;
        r.visible = 1'b1;
        r.sx = lerp_point(px, dx, t0);
        r.sy = lerp_point(py, dy, t0);
        r.ex = lerp_point(px, dx, t1);
        r.ey = lerp_point(py, dy, t1);
        r.t_in = t0[15:0];
        r.t_out = t1[15:0];
        return r;
    endfunction

    // Sender: prediction is made when a segment transfer completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                clip_expected.push_back(clip_segment(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (seg_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tdata  <= seg_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own.
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            if (hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
            else hold_done <= 1'b1;
        end
    end

    // Receiver and checker.
    always @(posedge aclk) begin
        clip_res_t want, got;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                       m_axis_tdata[47:32], m_axis_tdata[63:48],
                       m_axis_tdata[79:64], m_axis_tdata[95:80]};
                if (clip_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    want = clip_expected.pop_front();
                    if (got.visible !== want.visible) begin
                        $display("%0t: visible exp %0d got %0d", $time, want.visible,
                                 got.visible);
                        errors++;
                    end
                    if (got.sx !== want.sx) begin
                        $display("%0t: clip_start_x exp %h got %h", $time, want.sx, got.sx);
                        errors++;
                    end
                    if (got.sy !== want.sy) begin
                        $display("%0t: clip_start_y exp %h got %h", $time, want.sy, got.sy);
                        errors++;
                    end
                    if (got.ex !== want.ex) begin
                        $display("%0t: clip_end_x exp %h got %h", $time, want.ex, got.ex);
                        errors++;
                    end
                    if (got.ey !== want.ey) begin
                        $display("%0t: clip_end_y exp %h got %h", $time, want.ey, got.ey);
                        errors++;
                    end
                    if (got.t_in !== want.t_in) begin
                        $display("%0t: t_enter exp %h got %h", $time, want.t_in, got.t_in);
                        errors++;
                    end
                    if (got.t_out !== want.t_out) begin
                        $display("%0t: t_exit exp %h got %h", $time, want.t_out, got.t_out);
                        errors++;
                    end
                end
            end
            if (hold_go && !hold_done) m_axis_tready <= 1'b0;
            else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn) begin
            wdog <= 0;
        end else if (wdog >= WDOG_MAX) begin
            $display("** convex_polygon_line_clipper_core: FAILED **");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    // Keeps cfg_valid high across back-to-back writes; reg_write_end lowers it.
    task automatic reg_write(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_EDGE_COUNT) sh_edge_count = val[2:0];
        else if (idx >= REG_EDGE_FIRST && idx <= REG_EDGE_LAST)
            sh_edge[3'(idx - REG_EDGE_FIRST)] = val;
        else if (idx == REG_BBOX) sh_bbox = val;
    endtask

    task automatic reg_write_end();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] pack4(int a, int b, int c, int d);
        logic [15:0] la, lb, lc, ld;
        la = 16'(a); lb = 16'(b); lc = 16'(c); ld = 16'(d);
        return {ld, lc, lb, la};
    endfunction

    task automatic drain();
        wait (seg_queue.size() == 0 && !s_axis_tvalid && clip_expected.size() == 0);
        repeat (150) @(posedge aclk);
    endtask

    // Random segment: mostly around the polygon, some anywhere, some degenerate.
    function automatic logic [63:0] rand_seg();
        int sel, ax, ay, bx, by;
        sel = $urandom_range(99);
        ax = $urandom_range(32000) - 16000;
        ay = $urandom_range(32000) - 16000;
        bx = $urandom_range(32000) - 16000;
        by = $urandom_range(32000) - 16000;
        if (sel < 15) return {$urandom, $urandom};
        if (sel < 20) return pack4(ax, ay, ax, ay);
        if (sel < 25) return pack4(ax, ay, bx, ay);
        if (sel < 30) return pack4(ax, ay, ax, by);
        return pack4(ax, ay, bx, by);
    endfunction

    task automatic run_random(int count, int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
        for (int i = 0; i < count; i++) seg_queue.push_back(rand_seg());
        drain();
    endtask

    // Hexagon with apothem 12000 and inward normals of length one.
    int hex_o [6][2] = '{'{-12000, 0}, '{-6000, -10392}, '{6000, -10392},
                         '{12000, 0}, '{6000, 10392}, '{-6000, 10392}};
    int hex_n [6][2] = '{'{8192, 0}, '{4096, 7094}, '{-4096, 7094},
                         '{-8192, 0}, '{-4096, -7094}, '{4096, -7094}};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: all normals zero, degenerate box at the origin.
        seg_queue.push_back(pack4(0, 0, 0, 0));
        seg_queue.push_back(pack4(0, 0, 100, 0));
        seg_queue.push_back(pack4(5, 5, 9, 9));
        drain();

        // Square of side one: extremes, crossing, outside and parallel cases.
        reg_write(REG_EDGE_COUNT, 64'd4);
        reg_write(REG_EDGE_FIRST, pack4(-4096, -4096, 8192, 0));
        reg_write(REG_EDGE_FIRST + 8'd1, pack4(4096, 4096, -8192, 0));
        reg_write(REG_EDGE_FIRST + 8'd2, pack4(-4096, -4096, 0, 8192));
        reg_write(REG_EDGE_FIRST + 8'd3, pack4(4096, 4096, 0, -8192));
        reg_write(REG_BBOX, pack4(-4096, -4096, 4096, 4096));
        reg_write(REG_UNUSED, {$urandom, $urandom});
        reg_write_end();
        seg_queue.push_back(pack4(-32768, -32768, 32767, 32767));
        seg_queue.push_back(pack4(32767, 32767, -32768, -32768));
        seg_queue.push_back(pack4(-32768, 32767, 32767, -32768));
        seg_queue.push_back(pack4(32767, 0, -32768, 0));
        seg_queue.push_back(pack4(-32768, 10000, 32767, 10000));
        seg_queue.push_back(pack4(-1000, -1000, 1000, 1000));
        seg_queue.push_back(pack4(-4096, 0, 4096, 0));
        seg_queue.push_back(pack4(-8000, 0, 8000, 0));
        seg_queue.push_back(pack4(-8000, 8000, 8000, -8000));
        seg_queue.push_back(pack4(-6000, 0, -5000, 20000));
        seg_queue.push_back(pack4(-8000, 5000, 8000, 3000));
        seg_queue.push_back(pack4(5000, -5000, 20000, -5000));
        seg_queue.push_back(pack4(-8000, 3000, 3000, 8000));
        seg_queue.push_back(pack4(1234, 1234, 1234, 1234));
        seg_queue.push_back(pack4(-3000, 0, 3000, 0));
        drain();

        // Long hold-off while the sender keeps offering segments.
        hold_go <= 1'b1;
        run_random(130, 0);

        // Hexagon of six sides.
        reg_write(REG_EDGE_COUNT, 64'd6);
        for (int i = 0; i < 6; i++)
            reg_write(REG_EDGE_FIRST + CFG_IDX_BITS'(i),
                      pack4(hex_o[i][0], hex_o[i][1], hex_n[i][0], hex_n[i][1]));
        reg_write(REG_BBOX, pack4(-13856, -12000, 13856, 12000));
        reg_write_end();
        run_random(140, 1);

        // Count above the maximum with the widest box.
        reg_write(REG_EDGE_COUNT, 64'd7);
        reg_write(REG_BBOX, pack4(-32768, -32768, 32767, 32767));
        reg_write_end();
        run_random(130, 2);

        // Triangle of three sides.
        reg_write(REG_EDGE_COUNT, 64'd3);
        reg_write(REG_EDGE_FIRST, pack4(-6000, -6000, 0, 8192));
        reg_write(REG_EDGE_FIRST + 8'd1, pack4(-6000, -6000, 8192, 0));
        reg_write(REG_EDGE_FIRST + 8'd2, pack4(6000, -6000, -5000, -5000));
        reg_write(REG_BBOX, pack4(-6000, -6000, 6000, 6000));
        reg_write_end();
        run_random(140, 3);

        // Random values in every edge word and in the box.
        reg_write(REG_EDGE_COUNT, 64'd5);
        for (int i = 0; i < 6; i++)
            reg_write(REG_EDGE_FIRST + CFG_IDX_BITS'(i), {$urandom, $urandom});
        reg_write(REG_BBOX, {$urandom, $urandom});
        reg_write_end();
        run_random(130, 0);

        // No edges tested at all; only the box decides.
        reg_write(REG_EDGE_COUNT, 64'd0);
        reg_write(REG_BBOX, pack4(-10000, -8000, 9000, 7000));
        reg_write_end();
        run_random(130, 3);

        // Back to the hexagon with a tight box.
        reg_write(REG_EDGE_COUNT, 64'd6);
        for (int i = 0; i < 6; i++)
            reg_write(REG_EDGE_FIRST + CFG_IDX_BITS'(i),
                      pack4(hex_o[i][0], hex_o[i][1], hex_n[i][0], hex_n[i][1]));
        reg_write(REG_BBOX, pack4(-9000, -9000, 9000, 9000));
        reg_write_end();
        run_random(150, 2);

        if (errors == 0) begin
            $display("** convex_polygon_line_clipper_core: PASSED **");
        end else begin
            $display("** convex_polygon_line_clipper_core: FAILED **");
        end
        $finish;
    end
endmodule
